[rtl/thermometer_display_controller_top_macros.svh]
// assertion macros used by the checker file
`ifndef THERMOMETER_DISPLAY_CONTROLLER_TOP_MACROS_SVH
`define THERMOMETER_DISPLAY_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define TDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during rst
`define TDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tdc_pkg.sv]
// types, constants and the segment decoder of the thermometer display controller
package tdc_pkg;

  // converter and display widths
  localparam int ADC_BITS = 10;
  localparam int SHOWN_W  = 10;
  localparam int SEG_W    = 7;
  localparam int DIGITS   = 4;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // conversion scale factors, full scale over 2^ADC_BITS
  localparam int CEL_SCALE = 500;
  localparam int FAH_SCALE = 900;
  localparam int FAH_OFFSET = 32;

  // reciprocal multipliers for the decimal split, exact below 1024
  localparam int DIV10_MUL   = 205;
  localparam int DIV10_SHIFT = 11;
  localparam int DIV100_MUL   = 41;
  localparam int DIV100_SHIFT = 12;

  // register reset values
  localparam logic [7:0]         SAMPLE_PERIOD_RST = 8'd125;
  localparam logic [8:0]         FAN_THRESHOLD_RST = 9'd28;
  localparam logic [7:0]         FAN_ON_DUTY_RST   = 8'd51;
  localparam logic [SHOWN_W-1:0] SHOWN_RST         = 10'd123;

  // unit symbols
  localparam logic [SEG_W-1:0] SEG_F = 7'h71;
  localparam logic [SEG_W-1:0] SEG_C = 7'h39;

  // register map, word index
  typedef enum logic [1:0] {
    REG_SAMPLE_PERIOD = 2'd0,
    REG_FAN_THRESHOLD = 2'd1,
    REG_FAN_ON_DUTY   = 2'd2
  } tdc_reg_t;

  // display position sequence
  typedef enum logic [1:0] {
    POS_UNIT     = 2'd0,
    POS_ONES     = 2'd1,
    POS_TENS     = 2'd2,
    POS_HUNDREDS = 2'd3
  } tdc_pos_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] adc_sample;
    logic                button_pressed;
  } tdc_in_t;

  typedef struct packed {
    logic [DIGITS-1:0] digit_enable;
    logic [SEG_W-1:0]  segments;
    logic [7:0]        fan_duty;
    logic              shows_fahrenheit;
  } tdc_out_t;

  typedef struct packed {
    logic [7:0] sample_period;
    logic [8:0] fan_threshold;
    logic [7:0] fan_on_duty;
  } tdc_cfg_t;

  typedef struct packed {
    logic [SHOWN_W-1:0] cel;
    logic [SHOWN_W-1:0] fah;
    logic               fan_over;
  } tdc_conv_t;

  // standard seven-segment patterns, bit0 is segment a
  function automatic logic [SEG_W-1:0] seg_digit(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

[rtl/tdc_conv.sv]
// converter sample to Celsius and Fahrenheit, plus the fan threshold compare
module tdc_conv import tdc_pkg::*; (
  input  logic [ADC_BITS-1:0] adc,
  input  logic [8:0]          fan_threshold,
  output tdc_conv_t           conv
);

  localparam int CEL_W = ADC_BITS + 9;
  localparam int FAH_W = ADC_BITS + 10;

  logic [CEL_W-1:0] prod_cel;
  logic [FAH_W-1:0] prod_fah;

  // constant multiplies, the fraction dropped by the part-select
  assign prod_cel = CEL_W'(adc) * CEL_W'(CEL_SCALE);
  assign prod_fah = FAH_W'(adc) * FAH_W'(FAH_SCALE);

  assign conv.cel      = SHOWN_W'(prod_cel[CEL_W-1:ADC_BITS]);
  assign conv.fah      = prod_fah[FAH_W-1:ADC_BITS] + SHOWN_W'(FAH_OFFSET);
  // exact compare against the threshold scaled up to the product
  assign conv.fan_over = prod_cel > {fan_threshold, {ADC_BITS{1'b0}}};

endmodule

[rtl/tdc_seg.sv]
// decimal split of the shown value and segment pattern for one position
module tdc_seg import tdc_pkg::*; (
  input  logic [SHOWN_W-1:0] shown,
  input  tdc_pos_t           pos,
  input  logic               fahrenheit,
  output logic [SEG_W-1:0]   segments
);

  logic [SHOWN_W+7:0] prod10;
  logic [SHOWN_W+5:0] prod100;
  logic [6:0]         q10;
  logic [3:0]         q100;
  logic [SHOWN_W-1:0] ones_w;
  logic [6:0]         tens_w;
  logic [3:0]         hund;

  // divide by 10 and 100 through reciprocal multiplies
  assign prod10  = (SHOWN_W+8)'(shown) * (SHOWN_W+8)'(DIV10_MUL);
  assign prod100 = (SHOWN_W+6)'(shown) * (SHOWN_W+6)'(DIV100_MUL);
  assign q10     = prod10[DIV10_SHIFT+6:DIV10_SHIFT];
  assign q100    = prod100[DIV100_SHIFT+3:DIV100_SHIFT];

  // remainders give the digits
  assign ones_w = shown - SHOWN_W'(q10) * SHOWN_W'(10);
  assign tens_w = q10 - 7'(q100) * 7'd10;
  assign hund   = (q100 >= 4'd10) ? q100 - 4'd10 : q100;

  // pattern for the lit position
  always_comb begin
    unique case (pos)
      POS_UNIT:     segments = fahrenheit ? SEG_F : SEG_C;
      POS_ONES:     segments = seg_digit(ones_w[3:0]);
      POS_TENS:     segments = seg_digit(tens_w[3:0]);
      POS_HUNDREDS: segments = seg_digit(hund);
      default:      segments = '0;
    endcase
  end

endmodule

[rtl/tdc_core.sv]
// tick pipeline: input register, display and conversion state, result register
module tdc_core import tdc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  tdc_cfg_t cfg,
  input  logic     tick_valid,
  output logic     tick_stall,
  input  tdc_in_t  tick_data,
  output logic     drive_valid,
  input  logic     drive_stall,
  output tdc_out_t drive_data
);

  // input register
  logic    a_valid;
  tdc_in_t a_data;

  // display and conversion state
  logic [7:0]         tick_count, tick_count_next;
  tdc_pos_t           digit_index;
  logic [SHOWN_W-1:0] shown_value, shown_value_next;
  logic               scale_fahrenheit, scale_fahrenheit_next;
  logic               button_prev;
  logic [7:0]         fan_duty_held, fan_duty_held_next;

  logic             advance;
  logic             step;
  logic             convert;
  tdc_conv_t        conv;
  logic [SEG_W-1:0] seg;

  // result register frees when empty or when its beat is taken
  assign advance    = !drive_valid || !drive_stall;
  assign step       = a_valid && advance;
  assign tick_stall = a_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!tick_stall) begin
      a_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && !tick_stall) begin
      a_data <= tick_data;
    end
  end

  tdc_conv u_conv (
    .adc           (a_data.adc_sample),
    .fan_threshold (cfg.fan_threshold),
    .conv          (conv)
  );

  // button edge toggles the scale before anything else this tick
  assign scale_fahrenheit_next = scale_fahrenheit ^ (a_data.button_pressed & ~button_prev);

  tdc_seg u_seg (
    .shown      (shown_value),
    .pos        (digit_index),
    .fahrenheit (scale_fahrenheit_next),
    .segments   (seg)
  );

  // conversion counter and updated shown value and fan level
  always_comb begin
    convert            = tick_count >= cfg.sample_period;
    tick_count_next    = tick_count + 8'd1;
    shown_value_next   = shown_value;
    fan_duty_held_next = fan_duty_held;
    if (convert) begin
      tick_count_next    = tick_count + 8'd1 - cfg.sample_period;
      shown_value_next   = scale_fahrenheit_next ? conv.fah : conv.cel;
      fan_duty_held_next = conv.fan_over ? cfg.fan_on_duty : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count       <= '0;
      digit_index      <= POS_UNIT;
      shown_value      <= SHOWN_RST;
      scale_fahrenheit <= 1'b0;
      button_prev      <= 1'b0;
      fan_duty_held    <= '0;
    end else if (step) begin
      tick_count       <= tick_count_next;
      digit_index      <= tdc_pos_t'(digit_index + 2'd1);
      shown_value      <= shown_value_next;
      scale_fahrenheit <= scale_fahrenheit_next;
      button_prev      <= a_data.button_pressed;
      fan_duty_held    <= fan_duty_held_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (advance) begin
      drive_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      drive_data.digit_enable     <= DIGITS'(1) << digit_index;
      drive_data.segments         <= seg;
      drive_data.fan_duty         <= fan_duty_held_next;
      drive_data.shows_fahrenheit <= scale_fahrenheit_next;
    end
  end

endmodule

[rtl/tdc_cfg.sv]
// configuration registers behind the APB-style port
module tdc_cfg import tdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output tdc_cfg_t          cfg
);

  logic     wr_en;
  tdc_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = tdc_reg_t'(paddr[3:2]);

  // register writes, unmapped words ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_period <= SAMPLE_PERIOD_RST;
      cfg.fan_threshold <= FAN_THRESHOLD_RST;
      cfg.fan_on_duty   <= FAN_ON_DUTY_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SAMPLE_PERIOD: cfg.sample_period <= pwdata[7:0];
        REG_FAN_THRESHOLD: cfg.fan_threshold <= pwdata[8:0];
        REG_FAN_ON_DUTY:   cfg.fan_on_duty   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_SAMPLE_PERIOD: prdata = DATA_W'(cfg.sample_period);
      REG_FAN_THRESHOLD: prdata = DATA_W'(cfg.fan_threshold);
      REG_FAN_ON_DUTY:   prdata = DATA_W'(cfg.fan_on_duty);
      default:           prdata = '0;
    endcase
  end

endmodule

[rtl/thermometer_display_controller_top.sv]
// Four-position multiplexed seven-segment thermometer with fan level. Each tick
// beat carries a converter sample and the scale button level and yields one
// drive beat: the one-hot position, its segment pattern, the fan duty level
// and the scale flag. Positions run unit symbol, ones, tens, hundreds. A button
// rising edge swaps Celsius and Fahrenheit; every sample_period ticks the
// sample is converted and the shown value and fan level are refreshed. One
// tick is taken per clock while the drive port is not stalled; a tick's result
// passes through the input register and then the result register, on
// either side of the single-pass conversion and decode logic. Registers:
// sample_period at 0x0, fan_threshold at 0x4, fan_on_duty at 0x8; write only
// while idle.
module thermometer_display_controller_top import tdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick_valid,
  output logic              tick_stall,
  input  tdc_in_t           tick_data,
  output logic              drive_valid,
  input  logic              drive_stall,
  output tdc_out_t          drive_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  tdc_cfg_t cfg;

  tdc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tdc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .tick_valid  (tick_valid),
    .tick_stall  (tick_stall),
    .tick_data   (tick_data),
    .drive_valid (drive_valid),
    .drive_stall (drive_stall),
    .drive_data  (drive_data)
  );

endmodule

[rtl/tdc_checker.sv]
// port-level checker for the thermometer display controller and its bind
`include "thermometer_display_controller_top_macros.svh"

module tdc_checker import tdc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              drive_valid,
  input logic              drive_stall,
  input tdc_out_t          drive_data
);

  logic              drive_take;
  logic              have_last;
  logic [DIGITS-1:0] last_en;
  logic [DIGITS-1:0] rot_en;
  logic [SEG_W-1:0]  unit_seg;

  assign drive_take = drive_valid && !drive_stall;
  assign unit_seg   = drive_data.shows_fahrenheit ? SEG_F : SEG_C;
  assign rot_en     = {last_en[DIGITS-2:0], last_en[DIGITS-1]};

  // last position delivered, for the rotation check
  always_ff @(posedge clk) begin
    if (rst) begin
      have_last <= 1'b0;
      last_en   <= '0;
    end else if (drive_take) begin
      have_last <= 1'b1;
      last_en   <= drive_data.digit_enable;
    end
  end

  `TDC_ASSERT_IMP(a_onehot, drive_valid, $onehot(drive_data.digit_enable), "position not one-hot")
  `TDC_ASSERT_IMP(a_rotate, drive_take && have_last, drive_data.digit_enable == rot_en, "out of turn")
  `TDC_ASSERT_IMP(a_unit, drive_valid && drive_data.digit_enable[0], drive_data.segments == unit_seg, "unit wrong")
  `TDC_ASSERT_NEXT(a_hold, drive_valid && drive_stall, drive_valid && $stable(drive_data), "beat changed")

endmodule

bind thermometer_display_controller_top tdc_checker u_tdc_checker (.*);

[verif/tb_thermometer_display_controller_top.sv]
// self-checking testbench for the multiplexed seven-segment thermometer controller
`timescale 1ns / 100ps

module tb_thermometer_display_controller_top;
  import tdc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_AT = 900;
  localparam int HOLD_CYCLES = 300;
  localparam int CHUNK_ITEMS = 255;
  localparam logic [ADDR_W-1:0] ADDR_UNUSED = 4'hC;

  // scoreboard: predicts each drive beat from the accepted tick beats
  class display_scoreboard;
    tdc_out_t   drive_q[$];
    int         mismatches;
    logic [7:0] sample_period;
    logic [8:0] fan_threshold;
    logic [7:0] fan_on_duty;
    logic [7:0] tick_count;
    tdc_pos_t   position;
    logic [9:0] shown;
    logic       fahrenheit;
    logic       button_prev;
    logic [7:0] duty_held;

    function new();
      mismatches    = 0;
      sample_period = 8'd125;
      fan_threshold = 9'd28;
      fan_on_duty   = 8'd51;
      tick_count    = '0;
      position      = POS_UNIT;
      shown         = 10'd123;
      fahrenheit    = 1'b0;
      button_prev   = 1'b0;
      duty_held     = '0;
    endfunction

    function void set_reg(tdc_reg_t idx, logic [31:0] v);
      case (idx)
        REG_SAMPLE_PERIOD: sample_period = v[7:0];
        REG_FAN_THRESHOLD: fan_threshold = v[8:0];
        REG_FAN_ON_DUTY:   fan_on_duty   = v[7:0];
        default: ;
      endcase
    endfunction

    function logic [6:0] seven_seg(int d);
      logic [6:0] p;
      case (d)
        0: p = 7'h3F;
        1: p = 7'h06;
        2: p = 7'h5B;
        3: p = 7'h4F;
        4: p = 7'h66;
        5: p = 7'h6D;
        6: p = 7'h7D;
        7: p = 7'h07;
        8: p = 7'h7F;
        default: p = 7'h6F;
      endcase
      return p;
    endfunction

    // one tick: button edge, display the held value, then the conversion counter
    function void note_tick(tdc_in_t item);
      tdc_out_t want;
      int adc;
      int val;
      int cel;
      int fah;
      adc = int'(item.adc_sample);
      val = int'(shown);
      if (item.button_pressed && !button_prev) fahrenheit = !fahrenheit;
      button_prev = item.button_pressed;
      want.digit_enable = 4'b0001 << position;
      case (position)
        POS_UNIT: want.segments = fahrenheit ? SEG_F : SEG_C;
        POS_ONES: want.segments = seven_seg(val % 10);
        POS_TENS: want.segments = seven_seg((val / 10) % 10);
        default:  want.segments = seven_seg((val / 100) % 10);
      endcase
      position = tdc_pos_t'(position + 2'd1);
      if (tick_count < sample_period) begin
        tick_count = tick_count + 8'd1;
      end else begin
        tick_count = tick_count + 8'd1 - sample_period;
        cel = (adc * 500) / 1024;
        fah = (adc * 900) / 1024 + 32;
        shown = fahrenheit ? fah[9:0] : cel[9:0];
        duty_held = (adc * 500 > int'(fan_threshold) * 1024) ? fan_on_duty : 8'd0;
      end
      want.fan_duty = duty_held;
      want.shows_fahrenheit = fahrenheit;
      drive_q.push_back(want);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch on %s at %0t: got %0h, want %0h", what, $realtime, got, want);
      mismatches++;
    endtask

    task check_drive(tdc_out_t got);
      tdc_out_t want;
      if (drive_q.size() == 0) begin
        report_mismatch("unexpected drive beat", int'(got), 0);
      end else begin
        want = drive_q.pop_front();
        if (got.digit_enable != want.digit_enable)
          report_mismatch("digit_enable", int'(got.digit_enable), int'(want.digit_enable));
        if (got.segments != want.segments)
          report_mismatch("segments", int'(got.segments), int'(want.segments));
        if (got.fan_duty != want.fan_duty)
          report_mismatch("fan_duty", int'(got.fan_duty), int'(want.fan_duty));
        if (got.shows_fahrenheit != want.shows_fahrenheit)
          report_mismatch("shows_fahrenheit", int'(got.shows_fahrenheit),
                          int'(want.shows_fahrenheit));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              tick_valid;
  logic              tick_stall;
  tdc_in_t           tick_data;
  logic              drive_valid;
  logic              drive_stall;
  tdc_out_t          drive_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  display_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;
  logic button_level = 1'b0;

  thermometer_display_controller_top uut (
    .clk         (clk),
    .rst         (rst),
    .tick_valid  (tick_valid),
    .tick_stall  (tick_stall),
    .tick_data   (tick_data),
    .drive_valid (drive_valid),
    .drive_stall (drive_stall),
    .drive_data  (drive_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // drive sink: checks beats, random stall, one long hold-off
  initial begin : drive_sink
    int  hold_left;
    bit  held_once;
    int  seen;
    hold_left = 0;
    held_once = 1'b0;
    seen = 0;
    drive_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && drive_valid && !drive_stall) begin
        sb.check_drive(drive_data);
        seen++;
      end
      if (!held_once && seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        held_once = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        drive_stall <= 1'b1;
      end else begin
        drive_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic tdc_in_t make_tick(int adc, bit btn);
    tdc_in_t t;
    t.adc_sample = adc[ADC_BITS-1:0];
    t.button_pressed = btn;
    return t;
  endfunction

  // offer one tick beat after a random gap; valid stays high on return
  task automatic send_tick(tdc_in_t item);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick_data <= item;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    sb.note_tick(item);
  endtask

  // stop offering and wait for every predicted beat, then let the pipe settle
  task automatic drain();
    tick_valid <= 1'b0;
    while (sb.drive_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_reg(tdc_reg_t idx, int value);
    apb_write({idx, 2'b00}, value);
    sb.set_reg(idx, value);
  endtask

  // random ticks: mostly random samples, some extremes, button held for stretches
  task automatic run_chunk(int n);
    int adc;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(7);
      if (pick == 0) adc = 0;
      else if (pick == 1) adc = 1023;
      else if (pick == 2) adc = 1 << $urandom_range(9);
      else adc = $urandom_range(1023);
      if ($urandom_range(3) == 0) button_level = !button_level;
      send_tick(make_tick(adc, button_level));
    end
  endtask

  initial begin : stimulus
    int period;
    rst <= 1'b1;
    tick_valid <= 1'b0;
    tick_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset pattern, scale toggles, sample extremes, fan at full duty
    write_reg(REG_SAMPLE_PERIOD, 2);
    write_reg(REG_FAN_THRESHOLD, 0);
    write_reg(REG_FAN_ON_DUTY, 255);
    send_tick(make_tick(1023, 1'b0));
    send_tick(make_tick(0, 1'b0));
    send_tick(make_tick(1023, 1'b0));
    send_tick(make_tick(1, 1'b1));
    send_tick(make_tick(1, 1'b1));
    send_tick(make_tick(512, 1'b0));
    send_tick(make_tick(0, 1'b1));
    send_tick(make_tick(0, 1'b0));
    send_tick(make_tick(1023, 1'b1));
    send_tick(make_tick(1, 1'b0));
    send_tick(make_tick(5, 1'b0));
    send_tick(make_tick(0, 1'b0));
    drain();

    // period lowered below the running count
    write_reg(REG_SAMPLE_PERIOD, 255);
    for (int i = 0; i < 6; i++) send_tick(make_tick($urandom_range(1023), 1'b0));
    drain();
    write_reg(REG_SAMPLE_PERIOD, 2);
    send_tick(make_tick(700, 1'b0));
    send_tick(make_tick(300, 1'b0));
    drain();

    // zero period, threshold out of reach, zero duty, unused register
    write_reg(REG_SAMPLE_PERIOD, 0);
    write_reg(REG_FAN_THRESHOLD, 511);
    write_reg(REG_FAN_ON_DUTY, 0);
    apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    send_tick(make_tick(1023, 1'b0));
    send_tick(make_tick(1023, 1'b1));
    send_tick(make_tick(0, 1'b0));
    send_tick(make_tick(1023, 1'b0));
    drain();
    write_reg(REG_FAN_THRESHOLD, 498);
    write_reg(REG_FAN_ON_DUTY, 255);
    send_tick(make_tick(1023, 1'b0));
    send_tick(make_tick(512, 1'b0));
    drain();

    // random part: three idling modes, a fresh setting per chunk
    for (int c = 0; c < 6; c++) begin
      if (c < 2) begin
        send_idle_pct = 29;
        recv_idle_pct = 68;
      end else if (c < 4) begin
        send_idle_pct = 68;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(5))
        0:       period = 0;
        1:       period = 1;
        2:       period = 255;
        default: period = $urandom_range(2, 12);
      endcase
      write_reg(REG_SAMPLE_PERIOD, period);
      write_reg(REG_FAN_THRESHOLD, $urandom_range(0, 511));
      write_reg(REG_FAN_ON_DUTY, $urandom_range(0, 255));
      run_chunk(CHUNK_ITEMS);
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
